@@ design/ecal_pkg.sv @@
package ecal_pkg;

  // Register stages from input to output register
  localparam int STAGES = 9;

  localparam int IN_W   = 32;
  localparam int DATA_W = 48;
  localparam int USER_W = 2;

  typedef struct packed {
    logic        range_error;
    logic        summer_time;
    logic [11:0] year_number;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute;
    logic [5:0]  second;
  } result_t;

endpackage

@@ design/ecal_core.sv @@
module ecal_core (
  input  logic                         clk,
  input  logic [ecal_pkg::STAGES-1:0]  stage_en,
  input  logic [ecal_pkg::IN_W-1:0]    unix_seconds,
  output ecal_pkg::result_t            result
);
  import ecal_pkg::*;

  localparam logic [31:0] EPOCH_2000 = 32'd946684800;
  localparam logic [9:0]  DAY_UNIT   = 10'd675;          // 86400 >> 7
  localparam logic [25:0] RECIP_DAY  = 26'((64'd1 << 35) / 64'd675);
  localparam logic [11:0] RECIP_60S  = 12'((64'd1 << 17) / 64'd60);
  localparam logic [13:0] RECIP_7    = 14'((64'd1 << 16) / 64'd7);
  localparam logic [5:0]  RECIP_1461 = 6'((64'd1 << 16) / 64'd1461);
  localparam logic [5:0]  RECIP_60M  = 6'((64'd1 << 11) / 64'd60);
  // Day index of 2100-03-01; a phantom Feb 29 is inserted before it
  localparam logic [15:0] GAP_2100   = 16'd36584;

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    if (leap && m >= 4'd3) v = v + 9'd1;
    return v;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    case (m)
      4'd2:                       v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    v = 5'd30;
      default:                    v = 5'd31;
    endcase
    return v;
  endfunction

  // ---------------- stage 1: clamp and rebase to 2000 ----------------
  logic [31:0] p1_s_r;
  logic        p1_rerr_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      p1_rerr_r <= unix_seconds < EPOCH_2000;
      p1_s_r    <= (unix_seconds < EPOCH_2000) ? 32'd0 : unix_seconds - EPOCH_2000;
    end
  end

  // ---------------- stage 2: day estimate, s/128 * 1/675 ----------------
  logic [50:0] prod2;
  logic [15:0] p2_q0_r;
  logic [31:0] p2_s_r;
  logic        p2_rerr_r;

  assign prod2 = {26'b0, p1_s_r[31:7]} * {25'b0, RECIP_DAY};

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      p2_q0_r   <= prod2[50:35];
      p2_s_r    <= p1_s_r;
      p2_rerr_r <= p1_rerr_r;
    end
  end

  // ---------------- stage 3: day correction, seconds of day ----------------
  logic [25:0] qm3, r3;
  logic        fix3;
  logic [9:0]  rem7_3;
  logic [15:0] p3_days_r;
  logic [16:0] p3_sod_r;
  logic        p3_rerr_r;

  always_comb begin
    qm3    = {10'b0, p2_q0_r} * {16'b0, DAY_UNIT};
    r3     = {1'b0, p2_s_r[31:7]} - qm3;
    fix3   = r3[10:0] >= {1'b0, DAY_UNIT};
    rem7_3 = fix3 ? 10'(r3[10:0] - {1'b0, DAY_UNIT}) : r3[9:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      p3_days_r <= p2_q0_r + {15'b0, fix3};
      p3_sod_r  <= {rem7_3, p2_s_r[6:0]};
      p3_rerr_r <= p2_rerr_r;
    end
  end

  // ---------------- stage 4: minute, weekday and 4-year estimates ----------------
  logic [28:0] prod4m;
  logic [29:0] prod4w;
  logic [21:0] prod4q;
  logic [15:0] wd4, dadj4;
  logic [16:0] p4_sod_r;
  logic [15:0] p4_wd_r, p4_dadj_r;
  logic [11:0] p4_mq0_r;
  logic [13:0] p4_wq0_r;
  logic [5:0]  p4_qq0_r;
  logic        p4_rerr_r;

  always_comb begin
    wd4    = p3_days_r + 16'd6;
    dadj4  = p3_days_r + {15'b0, p3_days_r >= GAP_2100};
    prod4m = {12'b0, p3_sod_r} * {17'b0, RECIP_60S};
    prod4w = {14'b0, wd4} * {16'b0, RECIP_7};
    prod4q = {6'b0, dadj4} * {16'b0, RECIP_1461};
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      p4_sod_r  <= p3_sod_r;
      p4_wd_r   <= wd4;
      p4_dadj_r <= dadj4;
      p4_mq0_r  <= prod4m[28:17];
      p4_wq0_r  <= prod4w[29:16];
      p4_qq0_r  <= prod4q[21:16];
      p4_rerr_r <= p3_rerr_r;
    end
  end

  // ---------------- stage 5: corrections ----------------
  logic [17:0] mm5, mr5;
  logic [16:0] ww5, wr5, qq5, dr5;
  logic        fixm5, fixw5, fixq5;
  logic [10:0] p5_mt_r, p5_dq_r;
  logic [5:0]  p5_sec_r;
  logic [2:0]  p5_wday_r;
  logic [4:0]  p5_quad_r;
  logic        p5_rerr_r;
  logic [5:0]  quad5;

  always_comb begin
    mm5   = {6'b0, p4_mq0_r} * 18'd60;
    mr5   = {1'b0, p4_sod_r} - mm5;
    fixm5 = mr5[6:0] >= 7'd60;
    ww5   = {3'b0, p4_wq0_r} * 17'd7;
    wr5   = {1'b0, p4_wd_r} - ww5;
    fixw5 = wr5[3:0] >= 4'd7;
    qq5   = {11'b0, p4_qq0_r} * 17'd1461;
    dr5   = {1'b0, p4_dadj_r} - qq5;
    fixq5 = dr5[11:0] >= 12'd1461;
    quad5 = p4_qq0_r + {5'b0, fixq5};
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      p5_mt_r   <= p4_mq0_r[10:0] + {10'b0, fixm5};
      p5_sec_r  <= fixm5 ? 6'(mr5[6:0] - 7'd60) : mr5[5:0];
      p5_wday_r <= fixw5 ? 3'(wr5[3:0] - 4'd7) : wr5[2:0];
      p5_quad_r <= quad5[4:0];
      p5_dq_r   <= fixq5 ? 11'(dr5[11:0] - 12'd1461) : dr5[10:0];
      p5_rerr_r <= p4_rerr_r;
    end
  end

  // ---------------- stage 6: hour estimate, year and day of year ----------------
  logic [15:0] prod6;
  logic [1:0]  yoff6;
  logic [10:0] doy6;
  logic [10:0] p6_mt_r;
  logic [4:0]  p6_hq0_r;
  logic [5:0]  p6_sec_r;
  logic [2:0]  p6_wday_r;
  logic [8:0]  p6_doy_r;
  logic        p6_leap_r;
  logic [11:0] p6_year_r;
  logic        p6_rerr_r;

  always_comb begin
    prod6 = {5'b0, p5_mt_r} * {10'b0, RECIP_60M};
    if (p5_dq_r < 11'd366) begin
      yoff6 = 2'd0;
      doy6  = p5_dq_r;
    end else if (p5_dq_r < 11'd731) begin
      yoff6 = 2'd1;
      doy6  = p5_dq_r - 11'd366;
    end else if (p5_dq_r < 11'd1096) begin
      yoff6 = 2'd2;
      doy6  = p5_dq_r - 11'd731;
    end else begin
      yoff6 = 2'd3;
      doy6  = p5_dq_r - 11'd1096;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      p6_mt_r   <= p5_mt_r;
      p6_hq0_r  <= prod6[15:11];
      p6_sec_r  <= p5_sec_r;
      p6_wday_r <= p5_wday_r;
      p6_doy_r  <= doy6[8:0];
      p6_leap_r <= yoff6 == 2'd0;
      p6_year_r <= 12'd2000 + {5'b0, p5_quad_r, 2'b0} + {10'b0, yoff6};
      p6_rerr_r <= p5_rerr_r;
    end
  end

  // ---------------- stage 7: hour/minute, month ----------------
  logic [10:0] hm7, hr7;
  logic        fixh7;
  logic [3:0]  mon7;
  logic [5:0]  p7_sec_r, p7_min_r;
  logic [4:0]  p7_hour_r;
  logic [2:0]  p7_wday_r;
  logic [8:0]  p7_doy_r;
  logic        p7_leap_r;
  logic [3:0]  p7_mon_r;
  logic [11:0] p7_year_r;
  logic        p7_rerr_r;

  always_comb begin
    hm7   = {6'b0, p6_hq0_r} * 11'd60;
    hr7   = p6_mt_r - hm7;
    fixh7 = hr7[6:0] >= 7'd60;
    mon7  = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (p6_doy_r >= month_start(4'(m), p6_leap_r)) mon7 = 4'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      p7_sec_r  <= p6_sec_r;
      p7_min_r  <= fixh7 ? 6'(hr7[6:0] - 7'd60) : hr7[5:0];
      p7_hour_r <= p6_hq0_r + {4'b0, fixh7};
      p7_wday_r <= p6_wday_r;
      p7_doy_r  <= p6_doy_r;
      p7_leap_r <= p6_leap_r;
      p7_mon_r  <= mon7;
      p7_year_r <= p6_year_r;
      p7_rerr_r <= p6_rerr_r;
    end
  end

  // ---------------- stage 8: day of month ----------------
  logic [8:0]  mday8;
  logic [5:0]  p8_sec_r, p8_min_r;
  logic [4:0]  p8_hour_r, p8_mday_r;
  logic [2:0]  p8_wday_r;
  logic [3:0]  p8_mon_r;
  logic [11:0] p8_year_r;
  logic        p8_rerr_r;

  assign mday8 = p7_doy_r - month_start(p7_mon_r, p7_leap_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      p8_sec_r  <= p7_sec_r;
      p8_min_r  <= p7_min_r;
      p8_hour_r <= p7_hour_r;
      p8_wday_r <= p7_wday_r;
      p8_mday_r <= mday8[4:0];
      p8_mon_r  <= p7_mon_r;
      p8_year_r <= p7_year_r;
      p8_rerr_r <= p7_rerr_r;
    end
  end

  // ---------------- stage 9: summer time and rollover ----------------
  logic    past9, summer9, leap9;
  result_t res_nxt, res_r;

  always_comb begin
    leap9   = (p8_year_r[1:0] == 2'b00) && (p8_year_r != 12'd2100);
    // past the last Sunday of the month (at 02:00 on that Sunday)
    past9   = ({1'b0, p8_mday_r} >= ({3'b0, p8_wday_r} + 6'd25)) &&
              (p8_wday_r != 3'd0 || p8_hour_r >= 5'd2);
    if (p8_mon_r < 4'd3 || p8_mon_r > 4'd10) summer9 = 1'b0;
    else if (past9)                          summer9 = p8_mon_r != 4'd10;
    else                                     summer9 = p8_mon_r != 4'd3;

    res_nxt.second       = p8_sec_r;
    res_nxt.minute       = p8_min_r;
    res_nxt.hour_of_day  = p8_hour_r;
    res_nxt.weekday      = p8_wday_r;
    res_nxt.day_of_month = p8_mday_r;
    res_nxt.month_number = p8_mon_r;
    res_nxt.year_number  = p8_year_r;
    res_nxt.summer_time  = summer9;
    res_nxt.range_error  = p8_rerr_r;
    if (summer9) begin
      if (p8_hour_r == 5'd23) begin
        res_nxt.hour_of_day = 5'd0;
        res_nxt.weekday     = (p8_wday_r == 3'd6) ? 3'd0 : p8_wday_r + 3'd1;
        if (p8_mday_r >= days_in(p8_mon_r, leap9)) begin
          res_nxt.day_of_month = 5'd1;
          res_nxt.month_number = (p8_mon_r == 4'd12) ? 4'd1 : p8_mon_r + 4'd1;
        end else begin
          res_nxt.day_of_month = p8_mday_r + 5'd1;
        end
      end else begin
        res_nxt.hour_of_day = p8_hour_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

@@ design/epoch_seconds_to_local_calendar.sv @@
// Channel  Ports                  Payload
// -------  ---------------------  ------------------------------------------------
// input    in_tvalid/in_tready    in_tdata[31:0] = unix_seconds
// result   out_tvalid/out_tready  out_tdata = second..year_number, out_tuser = flags
//
// Nine register stages; a new item can enter every cycle when the output is not
// stalled. Throughput is set by the stage valid chain. Each stage loads when it
// is empty or the one after it moves, so bubbles are squeezed out and a stall
// holds every item in place. in_tready follows out_tready combinationally
// through that chain. rst_n clears the valid bits only.
module epoch_seconds_to_local_calendar (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ecal_pkg::IN_W-1:0]    in_tdata,   // [31:0] unix_seconds
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ecal_pkg::DATA_W-1:0]  out_tdata,  // second, minute, hour_of_day, weekday,
                                                   // day_of_month, month_number,
                                                   // year_number, zero pad
  output logic [ecal_pkg::USER_W-1:0]  out_tuser   // summer_time, range_error
);
  import ecal_pkg::*;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] stage_en;
  result_t           res;

  always_comb begin
    stage_en[STAGES-1] = !valid_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      stage_en[i] = !valid_r[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[0]) valid_r[0] <= in_tvalid;
      for (int i = 1; i < STAGES; i++) begin
        if (stage_en[i]) valid_r[i] <= valid_r[i-1];
      end
    end
  end

  ecal_core u_core (
    .clk          (clk),
    .stage_en     (stage_en),
    .unix_seconds (in_tdata),
    .result       (res)
  );

  assign in_tready  = stage_en[0];
  assign out_tvalid = valid_r[STAGES-1];
  assign out_tdata  = {7'b0, res.year_number, res.month_number, res.day_of_month,
                       res.weekday, res.hour_of_day, res.minute, res.second};
  assign out_tuser  = {res.range_error, res.summer_time};

endmodule
